FILE: sv/nested_section_self_timer_macros.svh
// Assertion macros for the profiler RTL.
`ifndef NESTED_SECTION_SELF_TIMER_MACROS_SVH
`define NESTED_SECTION_SELF_TIMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nst assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define NST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nst assertion failed: next-cycle implication");

`endif

FILE: sv/nst_pkg.sv
// Shared types and constants of the nested section self-time profiler.
package nst_pkg;

    localparam logic [15:0] DROP_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_RESET = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_END   = 2'd2
    } t_cmd;

    // command code with no meaning: consumed without a result
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        ST_PUSHED    = 3'd0,
        ST_CLOSED    = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_ABSORBED  = 3'd3,
        ST_UNMATCHED = 3'd4,
        ST_RESET     = 3'd5
    } t_status;

    // one registered input event
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] section_id;
        logic [63:0] timestamp;
    } t_event;

    // one result item
    typedef struct packed {
        t_status     status;
        logic [15:0] closed_id;
        logic [6:0]  closed_depth;
        logic [63:0] elapsed_time;
        logic [63:0] self_time;
        logic        overflow_seen;
    } t_result;

endpackage

FILE: sv/nested_section_self_timer.sv
// Top level of the nested section self-time profiler: stream ports, pipeline registers.
//
// Profiler for nested timed sections. Each beat carries a reset, begin or end
// event with a 64-bit timestamp and yields exactly one result beat (command
// code 3 is consumed with no result). The block takes one event per clock
// cycle while the result beat is not held back by the receiver; each event
// passes the input register, then the result register. One event a cycle is
// set by the top-of-stack registers plus the memory read port, which always
// holds the entry just below the top prefetched, so a pop and a parent
// child-time update finish together. Up to STACK_DEPTH sections may be open;
// begins beyond that are counted (saturating at 65535) and absorbed by later
// ends. The stack memory needs no clearing after reset.
`include "nested_section_self_timer_macros.svh"

module nested_section_self_timer #(
    parameter int STACK_DEPTH = 64,
    parameter int ID_WIDTH    = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [79:0]  i_s_tdata,   // section_id[15:0], timestamp[79:16]
    input  logic [1:0]   i_s_tuser,   // command[1:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [151:0] o_m_tdata,   // closed_id[15:0], closed_depth[22:16],
                                      // elapsed_time[86:23], self_time[150:87],
                                      // overflow_seen[151]
    output logic [2:0]   o_m_tuser    // status[2:0]
);
    import nst_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int EW = ID_WIDTH + 128;

    logic    r_in_vld;
    t_event  r_evt;
    logic    r_out_vld;
    t_result r_res;
    t_result res;
    logic    res_vld;
    logic    out_free, fire, in_acc;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, below;

    // handshake
    assign out_free   = !r_out_vld || i_m_tready;
    assign fire       = r_in_vld && out_free;
    assign o_s_tready = !r_in_vld || fire;
    assign in_acc     = i_s_tvalid && o_s_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_evt.command    <= i_s_tuser;
            r_evt.section_id <= i_s_tdata[15:0];
            r_evt.timestamp  <= i_s_tdata[79:16];
        end
    end

    nst_engine #(
        .STACK_DEPTH (STACK_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_evt     (r_evt),
        .o_res     (res),
        .o_res_vld (res_vld),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr   (raddr),
        .i_below   (below)
    );

    nst_stack_mem #(
        .DEPTH   (STACK_DEPTH),
        .ENTRY_W (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (below)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= res_vld;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_vld) begin
            r_res <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_res.status;
    assign o_m_tdata  = {r_res.overflow_seen, r_res.self_time, r_res.elapsed_time,
                         r_res.closed_depth, r_res.closed_id};

    // checks
    `NST_ASSERT_NXT(a_result_follows, i_clk, i_rst_n,
        fire && (r_evt.command != CMD_UNUSED), r_out_vld)
    `NST_ASSERT_NXT(a_reset_clears, i_clk, i_rst_n,
        fire && (r_evt.command == CMD_RESET), (o_m_tuser == ST_RESET) && !o_m_tdata[151])
    `NST_ASSERT_IMP(a_times_only_on_close, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser != ST_CLOSED), o_m_tdata[150:23] == '0)

endmodule

FILE: sv/nst_stack_mem.sv
// Stack body memory: one write port, one registered read port with write forwarding.
module nst_stack_mem #(
    parameter int DEPTH   = 64,
    parameter int ENTRY_W = 144
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [ENTRY_W-1:0]       i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [ENTRY_W-1:0]       o_rdata
);
    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd;
    logic [ENTRY_W-1:0] r_fwd_data;
    logic               r_fwd;

    // array write and registered read (read returns old data on a collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    // a push reads back the entry it writes: forward a copy in the cycle after the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= i_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_fwd_data <= i_wdata;
        end
    end

    assign o_rdata = r_fwd ? r_fwd_data : r_rd;

endmodule

FILE: sv/nst_engine.sv
// Event engine: stack state, top-of-stack registers and per-event result logic.
module nst_engine #(
    parameter int STACK_DEPTH = 64,
    parameter int ID_WIDTH    = 16,
    localparam int AW         = $clog2(STACK_DEPTH),
    localparam int EW         = ID_WIDTH + 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  nst_pkg::t_event  i_evt,
    output nst_pkg::t_result o_res,
    output logic             o_res_vld,
    output logic             o_we,
    output logic [AW-1:0]    o_waddr,
    output logic [EW-1:0]    o_wdata,
    output logic [AW-1:0]    o_raddr,
    input  logic [EW-1:0]    i_below
);
    import nst_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0]       r_count, n_count;
    logic [15:0]         r_dropped, n_dropped;
    logic                r_ovf, n_ovf;
    logic [ID_WIDTH-1:0] r_top_id, n_top_id;
    logic [63:0]         r_top_start, n_top_start;
    logic [63:0]         r_top_child, n_top_child;
    logic                top_load;

    logic [ID_WIDTH-1:0] b_id;
    logic [63:0]         b_start, b_child;
    logic [63:0]         elapsed, self_t;

    assign {b_id, b_start, b_child} = i_below;

    // close arithmetic, clamped at zero
    assign elapsed = (i_evt.timestamp >= r_top_start) ? i_evt.timestamp - r_top_start : 64'd0;
    assign self_t  = (elapsed >= r_top_child) ? elapsed - r_top_child : 64'd0;

    // next state and result
    always_comb begin
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_ovf       = r_ovf;
        n_top_id    = r_top_id;
        n_top_start = r_top_start;
        n_top_child = r_top_child;
        top_load    = 1'b0;
        o_we        = 1'b0;
        o_waddr     = AW'(r_count - CW'(1));
        o_wdata     = {r_top_id, r_top_start, r_top_child};
        o_res       = '0;
        o_res_vld   = 1'b0;
        unique case (i_evt.command)
            CMD_RESET: begin
                n_count   = '0;
                n_dropped = '0;
                n_ovf     = 1'b0;
                o_res_vld = 1'b1;
                o_res.status = ST_RESET;
            end
            CMD_BEGIN: begin
                o_res_vld = 1'b1;
                if (r_count == CW'(STACK_DEPTH)) begin
                    if (r_dropped != DROP_MAX) begin
                        n_dropped = r_dropped + 16'd1;
                    end
                    n_ovf        = 1'b1;
                    o_res.status = ST_DROPPED;
                end else begin
                    // old top moves into the memory, new entry becomes top
                    o_we        = (r_count != '0);
                    top_load    = 1'b1;
                    n_top_id    = ID_WIDTH'(i_evt.section_id);
                    n_top_start = i_evt.timestamp;
                    n_top_child = '0;
                    n_count     = r_count + CW'(1);
                    o_res.status = ST_PUSHED;
                end
            end
            CMD_END: begin
                o_res_vld = 1'b1;
                if (r_dropped != '0) begin
                    n_dropped    = r_dropped - 16'd1;
                    o_res.status = ST_ABSORBED;
                end else if (r_count == '0) begin
                    n_ovf        = 1'b1;
                    o_res.status = ST_UNMATCHED;
                end else begin
                    // parent comes up from the prefetched entry with its child time grown
                    n_count     = r_count - CW'(1);
                    top_load    = 1'b1;
                    n_top_id    = b_id;
                    n_top_start = b_start;
                    n_top_child = b_child + elapsed;
                    o_res.status       = ST_CLOSED;
                    o_res.closed_id    = 16'(r_top_id);
                    o_res.closed_depth = 7'(r_count);
                    o_res.elapsed_time = elapsed;
                    o_res.self_time    = self_t;
                end
            end
            default: begin
                o_res_vld = 1'b0;
            end
        endcase
        o_res.overflow_seen = n_ovf;
        if (!i_fire) begin
            o_we      = 1'b0;
            o_res_vld = 1'b0;
            n_count   = r_count;
        end
    end

    // keep the entry just below the top prefetched
    assign o_raddr = AW'(n_count - CW'(2));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= '0;
            r_ovf     <= 1'b0;
        end else if (i_fire) begin
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_ovf     <= n_ovf;
        end
    end

    // top-of-stack payload
    always_ff @(posedge i_clk) begin
        if (i_fire && top_load) begin
            r_top_id    <= n_top_id;
            r_top_start <= n_top_start;
            r_top_child <= n_top_child;
        end
    end

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the nested section self-time profiler.
`timescale 1ns / 1ps

module testbench;
    import nst_pkg::*;

    localparam int          STACK_DEPTH  = 64;
    localparam int          RAND_ITEMS   = 1400;
    localparam int          PHASE_ITEMS  = 350;
    localparam int          DROP_RUN     = 20;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam logic [63:0] T_MAX        = 64'hFFFF_FFFF_FFFF_FFFF;

    // one row of the directed table; res is used only when typed is set
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] id;
        logic [63:0] ts;
        logic [31:0] reps;
        logic        typed;
        t_result     res;
    } t_stim_row;

    logic         i_clk;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [79:0]  i_s_tdata  = '0;   // section_id[15:0], timestamp[79:16]
    logic [1:0]   i_s_tuser  = '0;   // command[1:0]
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b1;
    logic [151:0] o_m_tdata;         // closed_id[15:0], closed_depth[22:16],
                                     // elapsed_time[86:23], self_time[150:87],
                                     // overflow_seen[151]
    logic [2:0]   o_m_tuser;         // status[2:0]

    // shadow copy of the section stack
    logic [15:0]  sec_ids [STACK_DEPTH];
    logic [63:0]  sec_starts [STACK_DEPTH];
    logic [63:0]  sec_child [STACK_DEPTH];
    int unsigned  open_cnt  = 0;
    logic [15:0]  drop_cnt  = '0;
    logic         ovf_flag  = 1'b0;

    t_result      due_reports[$];
    t_stim_row    stim_rows[$];
    t_result      want;
    int           errors         = 0;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    int unsigned  cycle_cnt      = 0;

    nested_section_self_timer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, due_reports.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic t_result make_report(input t_status st, input logic [15:0] cid,
                                            input logic [6:0] depth, input logic [63:0] el,
                                            input logic [63:0] sf, input logic ovf);
        t_result r;
        r.status        = st;
        r.closed_id     = cid;
        r.closed_depth  = depth;
        r.elapsed_time  = el;
        r.self_time     = sf;
        r.overflow_seen = ovf;
        return r;
    endfunction

    task automatic add_row(input logic [1:0] cmd, input logic [15:0] id, input logic [63:0] ts,
                           input int reps, input logic typed, input t_result res);
        t_stim_row row;
        row.cmd   = cmd;
        row.id    = id;
        row.ts    = ts;
        row.reps  = reps;
        row.typed = typed;
        row.res   = res;
        stim_rows.push_back(row);
    endtask

    // next-state and result of the profiler for one event
    task automatic profile_event(input logic [1:0] cmd, input logic [15:0] id,
                                 input logic [63:0] ts, output logic has_res,
                                 output t_result res);
        int unsigned top;
        logic [63:0] elapsed;
        logic [63:0] own_time;
        res     = '0;
        has_res = 1'b1;
        case (cmd)
            CMD_RESET: begin
                open_cnt   = 0;
                drop_cnt   = '0;
                ovf_flag   = 1'b0;
                res.status = ST_RESET;
            end
            CMD_BEGIN: begin
                if (open_cnt >= STACK_DEPTH) begin
                    if (drop_cnt != DROP_MAX)
                        drop_cnt = drop_cnt + 1'b1;
                    ovf_flag   = 1'b1;
                    res.status = ST_DROPPED;
                end else begin
                    sec_ids[open_cnt]    = id;
                    sec_starts[open_cnt] = ts;
                    sec_child[open_cnt]  = '0;
                    open_cnt             = open_cnt + 1;
                    res.status           = ST_PUSHED;
                end
            end
            CMD_END: begin
                if (drop_cnt != 0) begin
                    drop_cnt   = drop_cnt - 1'b1;
                    res.status = ST_ABSORBED;
                end else if (open_cnt == 0) begin
                    ovf_flag   = 1'b1;
                    res.status = ST_UNMATCHED;
                end else begin
                    top      = open_cnt - 1;
                    elapsed  = (ts >= sec_starts[top]) ? ts - sec_starts[top] : '0;
                    own_time = (elapsed >= sec_child[top]) ? elapsed - sec_child[top] : '0;
                    res.status       = ST_CLOSED;
                    res.closed_id    = sec_ids[top];
                    res.closed_depth = 7'(open_cnt);
                    res.elapsed_time = elapsed;
                    res.self_time    = own_time;
                    open_cnt         = top;
                    // parent child time wraps at 64 bits
                    if (open_cnt > 0)
                        sec_child[open_cnt - 1] = sec_child[open_cnt - 1] + elapsed;
                end
            end
            default: has_res = 1'b0;
        endcase
        res.overflow_seen = ovf_flag;
    endtask

    // one input beat, with random idle cycles in front
    task automatic drive_event(input logic [1:0] cmd, input logic [15:0] id,
                               input logic [63:0] ts);
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {ts, id};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (due_reports.size() == 0) begin
                $display("%0t: result beat with nothing due, expected none, got status %0d",
                         $time, o_m_tuser);
                errors++;
            end else begin
                want = due_reports.pop_front();
                check_field("status", 64'(want.status), 64'(o_m_tuser));
                check_field("closed_id", 64'(want.closed_id), 64'(o_m_tdata[15:0]));
                check_field("closed_depth", 64'(want.closed_depth), 64'(o_m_tdata[22:16]));
                check_field("elapsed_time", want.elapsed_time, o_m_tdata[86:23]);
                check_field("self_time", want.self_time, o_m_tdata[150:87]);
                check_field("overflow_seen", 64'(want.overflow_seen), 64'(o_m_tdata[151]));
            end
        end
    end

    // stimulus
    initial begin
        logic        has_res;
        t_result     pred;
        logic [1:0]  cmd;
        logic [15:0] id;
        logic [63:0] ts;
        logic [63:0] clock_now;
        int          rand_done;
        int          begin_bias;
        int          pick;

        // directed table
        add_row(CMD_RESET, 16'h0000, 64'd0, 1, 1'b1,
                make_report(ST_RESET, 16'd0, 7'd0, 64'd0, 64'd0, 1'b0));
        add_row(CMD_END, 16'h0000, 64'd0, 1, 1'b1,
                make_report(ST_UNMATCHED, 16'd0, 7'd0, 64'd0, 64'd0, 1'b1));
        add_row(CMD_UNUSED, 16'hFFFF, T_MAX, 1, 1'b0, '0);
        add_row(CMD_RESET, 16'hFFFF, T_MAX, 1, 1'b1,
                make_report(ST_RESET, 16'd0, 7'd0, 64'd0, 64'd0, 1'b0));
        add_row(CMD_BEGIN, 16'hFFFF, 64'd0, 1, 1'b1,
                make_report(ST_PUSHED, 16'd0, 7'd0, 64'd0, 64'd0, 1'b0));
        add_row(CMD_BEGIN, 16'h0000, 64'd100, 1, 1'b1,
                make_report(ST_PUSHED, 16'd0, 7'd0, 64'd0, 64'd0, 1'b0));
        // end before start: times clamp at zero
        add_row(CMD_END, 16'h0000, 64'd50, 1, 1'b1,
                make_report(ST_CLOSED, 16'h0000, 7'd2, 64'd0, 64'd0, 1'b0));
        add_row(CMD_END, 16'h0000, T_MAX, 1, 1'b1,
                make_report(ST_CLOSED, 16'hFFFF, 7'd1, T_MAX, T_MAX, 1'b0));
        // parent child time wraps past 2^64
        add_row(CMD_BEGIN, 16'h00A1, 64'd0, 1, 1'b0, '0);
        add_row(CMD_BEGIN, 16'h00A2, 64'd0, 1, 1'b0, '0);
        add_row(CMD_END, 16'h0000, T_MAX, 1, 1'b0, '0);
        add_row(CMD_BEGIN, 16'h00A3, 64'd0, 1, 1'b0, '0);
        add_row(CMD_END, 16'h0000, 64'd2, 1, 1'b0, '0);
        add_row(CMD_END, 16'h0000, 64'd5, 1, 1'b0, '0);
        // child time larger than elapsed: self time clamps
        add_row(CMD_BEGIN, 16'h00B1, 64'd10, 1, 1'b0, '0);
        add_row(CMD_BEGIN, 16'h00B2, 64'd0, 1, 1'b0, '0);
        add_row(CMD_END, 16'h0000, 64'd100, 1, 1'b0, '0);
        add_row(CMD_END, 16'h0000, 64'd20, 1, 1'b0, '0);
        // fill the stack, then drop a run of begins and absorb them with ends
        add_row(CMD_RESET, 16'h0000, 64'd0, 1, 1'b1,
                make_report(ST_RESET, 16'd0, 7'd0, 64'd0, 64'd0, 1'b0));
        add_row(CMD_BEGIN, 16'h5555, 64'd1000, STACK_DEPTH, 1'b0, '0);
        add_row(CMD_BEGIN, 16'hAAAA, 64'd2000, DROP_RUN, 1'b1,
                make_report(ST_DROPPED, 16'd0, 7'd0, 64'd0, 64'd0, 1'b1));
        add_row(CMD_END, 16'h0000, 64'd3000, DROP_RUN, 1'b1,
                make_report(ST_ABSORBED, 16'd0, 7'd0, 64'd0, 64'd0, 1'b1));
        add_row(CMD_END, 16'h0000, 64'd4000, STACK_DEPTH, 1'b0, '0);
        add_row(CMD_END, 16'h0000, 64'd4000, 1, 1'b1,
                make_report(ST_UNMATCHED, 16'd0, 7'd0, 64'd0, 64'd0, 1'b1));
        add_row(CMD_RESET, 16'h0000, 64'd0, 1, 1'b1,
                make_report(ST_RESET, 16'd0, 7'd0, 64'd0, 64'd0, 1'b0));

        // reset
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        foreach (stim_rows[r]) begin
            for (int k = 0; k < stim_rows[r].reps; k++) begin
                drive_event(stim_rows[r].cmd, stim_rows[r].id, stim_rows[r].ts);
                profile_event(stim_rows[r].cmd, stim_rows[r].id, stim_rows[r].ts, has_res, pred);
                if (stim_rows[r].typed)
                    pred = stim_rows[r].res;
                if (has_res)
                    due_reports.push_back(pred);
            end
        end

        // random part: mostly nested begin/end runs on a rising clock
        rand_done  = 0;
        begin_bias = 55;
        clock_now  = 64'd0;
        while (rand_done < RAND_ITEMS) begin
            if (rand_done % PHASE_ITEMS == 0) begin
                case (rand_done / PHASE_ITEMS)
                    0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                    1: begin src_idle_pct = 84; sink_stall_pct = 0;  end
                    2: begin src_idle_pct = 0;  sink_stall_pct = 84; end
                    default: begin src_idle_pct = 34; sink_stall_pct = 34; end
                endcase
            end
            // nesting tendency changes every hundred events
            if (rand_done % 100 == 0) begin
                case ($urandom_range(3))
                    0: begin_bias = 20;
                    1: begin_bias = 45;
                    2: begin_bias = 55;
                    default: begin_bias = 90;
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 2)
                cmd = CMD_RESET;
            else if (pick < 4)
                cmd = CMD_UNUSED;
            else if ($urandom_range(99) < begin_bias)
                cmd = CMD_BEGIN;
            else
                cmd = CMD_END;
            id   = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 3) begin
                clock_now = {$urandom, $urandom};
                ts        = clock_now;
            end else if (pick < 6) begin
                ts = {$urandom, $urandom};
            end else begin
                clock_now = clock_now + 64'($urandom_range(2000));
                ts        = clock_now;
            end
            drive_event(cmd, id, ts);
            profile_event(cmd, id, ts, has_res, pred);
            if (has_res) begin
                due_reports.push_back(pred);
                rand_done++;
            end
        end
        i_s_tvalid <= 1'b0;

        // drain
        while (due_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
